// ===== sv/glt_pkg.sv =====
// shared types and constants for the grid line tile walker
package glt_pkg;

    localparam int MAX_TILES = 64;
    localparam int REM_W     = $clog2(MAX_TILES);
    localparam int COORD_W   = 24;
    localparam int TILE_W    = 16;
    localparam int DELTA_W   = 24;
    localparam int FRAC_W    = 9;
    localparam int PROD_W    = FRAC_W + DELTA_W;
    localparam int CROSS_W   = 48;

    // step mode of a run
    localparam logic [1:0] MODE_ROW  = 2'd0;
    localparam logic [1:0] MODE_COL  = 2'd1;
    localparam logic [1:0] MODE_DIAG = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] end_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] start_x;
    } seg_t;

    typedef struct packed {
        logic [TILE_W-1:0]  tile_x;
        logic [TILE_W-1:0]  tile_y;
        logic               neg_x;
        logic               neg_y;
        logic [DELTA_W-1:0] mdx;
        logic [DELTA_W-1:0] mdy;
        logic [FRAC_W-1:0]  fx;
        logic [FRAC_W-1:0]  fy;
        logic [REM_W-1:0]   remaining;
        logic               trunc;
        logic [1:0]         mode;
    } setup_t;

endpackage

// ===== sv/glt_setup.sv =====
// start tile, direction, deltas, first boundary distances and run length of a segment
module glt_setup (
    input  glt_pkg::seg_t   seg,
    output glt_pkg::setup_t setup
);

    logic signed [glt_pkg::COORD_W:0]  dx;
    logic signed [glt_pkg::COORD_W:0]  dy;
    logic [glt_pkg::TILE_W-1:0]        tx;
    logic [glt_pkg::TILE_W-1:0]        ty;
    logic [glt_pkg::TILE_W-1:0]        etx;
    logic [glt_pkg::TILE_W-1:0]        ety;
    logic signed [glt_pkg::TILE_W:0]   dtx;
    logic signed [glt_pkg::TILE_W:0]   dty;
    logic [glt_pkg::TILE_W-1:0]        adtx;
    logic [glt_pkg::TILE_W-1:0]        adty;
    logic [glt_pkg::TILE_W:0]          span;
    logic                              trunc;

    // segment deltas in fraction units
    assign dx = $signed({seg.end_x[glt_pkg::COORD_W-1], seg.end_x})
              - $signed({seg.start_x[glt_pkg::COORD_W-1], seg.start_x});
    assign dy = $signed({seg.end_y[glt_pkg::COORD_W-1], seg.end_y})
              - $signed({seg.start_y[glt_pkg::COORD_W-1], seg.start_y});

    // floor to tile is the upper bits
    assign tx  = seg.start_x[glt_pkg::COORD_W-1:8];
    assign ty  = seg.start_y[glt_pkg::COORD_W-1:8];
    assign etx = seg.end_x[glt_pkg::COORD_W-1:8];
    assign ety = seg.end_y[glt_pkg::COORD_W-1:8];

    // tile distance per axis
    assign dtx  = $signed({etx[glt_pkg::TILE_W-1], etx}) - $signed({tx[glt_pkg::TILE_W-1], tx});
    assign dty  = $signed({ety[glt_pkg::TILE_W-1], ety}) - $signed({ty[glt_pkg::TILE_W-1], ty});
    assign adtx = dtx[glt_pkg::TILE_W] ? glt_pkg::TILE_W'(-dtx) : dtx[glt_pkg::TILE_W-1:0];
    assign adty = dty[glt_pkg::TILE_W] ? glt_pkg::TILE_W'(-dty) : dty[glt_pkg::TILE_W-1:0];

    // tiles after the first one
    assign span  = {1'b0, adtx} + {1'b0, adty};
    assign trunc = span >= (glt_pkg::TILE_W+1)'(glt_pkg::MAX_TILES);

    always_comb begin
        setup.tile_x    = tx;
        setup.tile_y    = ty;
        setup.neg_x     = dx[glt_pkg::COORD_W];
        setup.neg_y     = dy[glt_pkg::COORD_W];
        setup.mdx       = dx[glt_pkg::COORD_W] ? glt_pkg::DELTA_W'(-dx)
                                               : dx[glt_pkg::DELTA_W-1:0];
        setup.mdy       = dy[glt_pkg::COORD_W] ? glt_pkg::DELTA_W'(-dy)
                                               : dy[glt_pkg::DELTA_W-1:0];
        // distance to first boundary: back to the tile floor or up to the next one
        setup.fx        = dx[glt_pkg::COORD_W] ? {1'b0, seg.start_x[7:0]}
                                               : 9'd256 - {1'b0, seg.start_x[7:0]};
        setup.fy        = dy[glt_pkg::COORD_W] ? {1'b0, seg.start_y[7:0]}
                                               : 9'd256 - {1'b0, seg.start_y[7:0]};
        setup.trunc     = trunc;
        setup.remaining = trunc ? glt_pkg::REM_W'(glt_pkg::MAX_TILES - 1)
                                : span[glt_pkg::REM_W-1:0];
        if (ty == ety) begin
            setup.mode = glt_pkg::MODE_ROW;
        end else if (tx == etx) begin
            setup.mode = glt_pkg::MODE_COL;
        end else begin
            setup.mode = glt_pkg::MODE_DIAG;
        end
    end

endmodule

// ===== sv/glt_mul.sv =====
// shared multiplier for the two cross products of the first boundary distances
module glt_mul (
    input  logic [glt_pkg::FRAC_W-1:0]  a,
    input  logic [glt_pkg::DELTA_W-1:0] b,
    output logic [glt_pkg::PROD_W-1:0]  p
);

    // unsigned 9 x 24 product
    assign p = glt_pkg::PROD_W'(a) * glt_pkg::PROD_W'(b);

endmodule

// ===== sv/grid_line_tile_walker.sv =====
// top level of the grid line tile walker
// Takes one segment per input beat on s_axis and emits, on m_axis, one beat
// per grid tile that the segment crosses, 4-connected, start tile first.
// s_axis_tdata carries start_x, start_y, end_x, end_y (24-bit signed, 8
// fraction bits each). m_axis_tdata carries tile_x and tile_y (16-bit
// signed), m_axis_tlast marks the final tile and m_axis_tuser[0] is set on
// every tile of a run cut at 64 tiles.
// After an input beat is taken, the PREP state computes the start tile, deltas
// and run length, then one shared 9 x 24 multiplier forms the two cross products
// in the MULX and MULY states. The walk then steps one tile per cycle, unless a
// stall on m_axis_tready holds it, through one shared compare and 48-bit add.
// s_axis_tready is high only between runs; it rises while the final tile may
// still wait in the output register.
// A stall on m_axis_tready holds the walk with the tile in the output register.
// Synchronous active-low reset returns to idle and drops m_axis_tvalid.
module grid_line_tile_walker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // start_x, start_y, end_x, end_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // tile_x, tile_y
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser   // truncated
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MULX = 3'd2;
    localparam logic [2:0] S_MULY = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;

    logic [2:0]                        state_reg;
    glt_pkg::seg_t                     seg_reg;
    glt_pkg::setup_t                   setup_comb;
    glt_pkg::setup_t                   setup_reg;
    logic [glt_pkg::TILE_W-1:0]        cur_x_reg;
    logic [glt_pkg::TILE_W-1:0]        cur_y_reg;
    logic [glt_pkg::REM_W-1:0]         rem_reg;
    logic [glt_pkg::CROSS_W-1:0]       ncx_reg;
    logic [glt_pkg::CROSS_W-1:0]       ncy_reg;
    logic [glt_pkg::FRAC_W-1:0]        mul_a;
    logic [glt_pkg::DELTA_W-1:0]       mul_b;
    logic [glt_pkg::PROD_W-1:0]        mul_p;
    logic                              pick_x;
    logic [glt_pkg::CROSS_W-1:0]       cross_sum;
    logic                              emit;
    logic                              m_valid_reg;
    logic [glt_pkg::TILE_W-1:0]        out_x_reg;
    logic [glt_pkg::TILE_W-1:0]        out_y_reg;
    logic                              out_last_reg;
    logic                              out_trunc_reg;

    assign s_axis_tready = (state_reg == S_IDLE);

    glt_setup u_setup (
        .seg   (seg_reg),
        .setup (setup_comb)
    );

    // one multiplier serves both cross products
    assign mul_a = (state_reg == S_MULX) ? setup_reg.fx  : setup_reg.fy;
    assign mul_b = (state_reg == S_MULX) ? setup_reg.mdy : setup_reg.mdx;

    glt_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    // shared compare and add: nearer x crossing steps x, a tie steps y
    assign pick_x    = ncx_reg < ncy_reg;
    assign cross_sum = (pick_x ? ncx_reg : ncy_reg)
                     + glt_pkg::CROSS_W'({(pick_x ? setup_reg.mdy : setup_reg.mdx), 8'd0});

    assign emit = (state_reg == S_WALK) && (!m_valid_reg || m_axis_tready);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: state_reg <= S_MULX;
                S_MULX: state_reg <= S_MULY;
                S_MULY: state_reg <= S_WALK;
                S_WALK: begin
                    if (emit && rem_reg == '0) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // walk datapath
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            seg_reg <= s_axis_tdata;
        end
        if (state_reg == S_PREP) begin
            setup_reg <= setup_comb;
            cur_x_reg <= setup_comb.tile_x;
            cur_y_reg <= setup_comb.tile_y;
            rem_reg   <= setup_comb.remaining;
        end
        if (state_reg == S_MULX) begin
            ncx_reg <= glt_pkg::CROSS_W'(mul_p);
        end
        if (state_reg == S_MULY) begin
            ncy_reg <= glt_pkg::CROSS_W'(mul_p);
        end
        if (emit && rem_reg != '0) begin
            rem_reg <= rem_reg - glt_pkg::REM_W'(1);
            case (setup_reg.mode)
                glt_pkg::MODE_ROW: begin
                    cur_x_reg <= setup_reg.neg_x ? cur_x_reg - glt_pkg::TILE_W'(1)
                                                 : cur_x_reg + glt_pkg::TILE_W'(1);
                end
                glt_pkg::MODE_COL: begin
                    cur_y_reg <= setup_reg.neg_y ? cur_y_reg - glt_pkg::TILE_W'(1)
                                                 : cur_y_reg + glt_pkg::TILE_W'(1);
                end
                default: begin
                    if (pick_x) begin
                        cur_x_reg <= setup_reg.neg_x ? cur_x_reg - glt_pkg::TILE_W'(1)
                                                     : cur_x_reg + glt_pkg::TILE_W'(1);
                        ncx_reg   <= cross_sum;
                    end else begin
                        cur_y_reg <= setup_reg.neg_y ? cur_y_reg - glt_pkg::TILE_W'(1)
                                                     : cur_y_reg + glt_pkg::TILE_W'(1);
                        ncy_reg   <= cross_sum;
                    end
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_x_reg     <= cur_x_reg;
            out_y_reg     <= cur_y_reg;
            out_last_reg  <= (rem_reg == '0);
            out_trunc_reg <= setup_reg.trunc;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_trunc_reg;

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the grid line tile walker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_SEGS = 300;
    localparam int CYCLE_LIMIT = 1000000;

    // one expected tile beat
    typedef struct {
        logic [glt_pkg::TILE_W-1:0] x;
        logic [glt_pkg::TILE_W-1:0] y;
        logic                       last;
        logic                       cut;
    } tile_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;  // start_x, start_y, end_x, end_y
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // tile_x, tile_y
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;       // truncated

    glt_pkg::seg_t seg_q[$];
    tile_t         tile_q[$];
    int            segs_sent = 0;
    int            segs_taken = 0;
    int            segs_total = 0;
    int            burst_left = 0;
    int            gap_left = 0;
    int            stall_left = 0;
    int            rx_cycle = 0;
    int            cycle_cnt = 0;
    bit            failed = 1'b0;

    grid_line_tile_walker DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // appends one segment to the pending queue
    task automatic queue_seg(input glt_pkg::seg_t s);
        seg_q.insert(seg_q.size(), s);
    endtask

    // works out the tile run of one segment and queues every tile of it
    task automatic walk_segment(input glt_pkg::seg_t seg);
        logic signed [glt_pkg::COORD_W-1:0] sx, sy, ex, ey;
        logic signed [glt_pkg::TILE_W-1:0]  tx, ty, etx, ety, cx, cy;
        logic [63:0]                        mdx, mdy, fx, fy, cross_x, cross_y;
        logic [1:0]                         mode;
        int                                 dtx, dty, total, n;
        bit                                 cut, negx, negy;
        tile_t                              t;
        sx = seg.start_x;
        sy = seg.start_y;
        ex = seg.end_x;
        ey = seg.end_y;
        tx = sx >>> 8;
        ty = sy >>> 8;
        etx = ex >>> 8;
        ety = ey >>> 8;
        dtx = int'(etx) - int'(tx);
        dty = int'(ety) - int'(ty);
        total = (dtx < 0 ? -dtx : dtx) + (dty < 0 ? -dty : dty) + 1;
        cut = total > glt_pkg::MAX_TILES;
        n = cut ? glt_pkg::MAX_TILES : total;
        negx = ex < sx;
        negy = ey < sy;
        mdx = negx ? 64'(int'(sx) - int'(ex)) : 64'(int'(ex) - int'(sx));
        mdy = negy ? 64'(int'(sy) - int'(ey)) : 64'(int'(ey) - int'(sy));
        // distance to the first boundary, a full tile when moving up from one
        fx = negx ? {56'd0, sx[7:0]} : 64'd256 - {56'd0, sx[7:0]};
        fy = negy ? {56'd0, sy[7:0]} : 64'd256 - {56'd0, sy[7:0]};
        cross_x = fx * mdy;
        cross_y = fy * mdx;
        if (ty == ety) begin
            mode = glt_pkg::MODE_ROW;
        end else if (tx == etx) begin
            mode = glt_pkg::MODE_COL;
        end else begin
            mode = glt_pkg::MODE_DIAG;
        end
        cx = tx;
        cy = ty;
        for (int i = 0; i < n; i++) begin
            t.x = cx;
            t.y = cy;
            t.last = (i == n - 1);
            t.cut = cut;
            tile_q.insert(tile_q.size(), t);
            // nearer crossing wins, a tie steps y
            if (mode == glt_pkg::MODE_ROW
                || (mode == glt_pkg::MODE_DIAG && cross_x < cross_y)) begin
                cx = negx ? cx - 16'sd1 : cx + 16'sd1;
                cross_x = cross_x + 64'd256 * mdy;
            end else begin
                cy = negy ? cy - 16'sd1 : cy + 16'sd1;
                cross_y = cross_y + 64'd256 * mdx;
            end
        end
    endtask

    function automatic glt_pkg::seg_t make_seg(int sx, int sy, int ex, int ey);
        glt_pkg::seg_t s;
        s.start_x = sx[23:0];
        s.start_y = sy[23:0];
        s.end_x = ex[23:0];
        s.end_y = ey[23:0];
        return s;
    endfunction

    // random coordinate, often right on a tile boundary
    function automatic logic [glt_pkg::COORD_W-1:0] rand_coord();
        logic [glt_pkg::COORD_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 3) == 0) v[7:0] = 8'd0;
        return v;
    endfunction

    // mostly short segments anywhere on the grid, some long ones that get cut
    function automatic glt_pkg::seg_t rand_seg();
        glt_pkg::seg_t s;
        int            kind, span, dx, dy;
        kind = $urandom_range(0, 99);
        s.start_x = rand_coord();
        s.start_y = rand_coord();
        if (kind < 12) begin
            s.end_x = rand_coord();
            s.end_y = rand_coord();
        end else begin
            span = (kind < 22) ? 40 * 256 : 6 * 256;
            dx = int'($urandom_range(0, 2 * span)) - span;
            dy = int'($urandom_range(0, 2 * span)) - span;
            s.end_x = s.start_x + dx[23:0];
            s.end_y = s.start_y + dy[23:0];
            if ($urandom_range(0, 3) == 0) s.end_x[7:0] = 8'd0;
            if ($urandom_range(0, 3) == 0) s.end_y[7:0] = 8'd0;
            // keep the row or the column of the start tile
            if (kind >= 22 && kind < 32) s.end_y[23:8] = s.start_y[23:8];
            if (kind >= 32 && kind < 42) s.end_x[23:8] = s.start_x[23:8];
        end
        return s;
    endfunction

    // driver: bursts of segments with random gaps, held until taken
    always @(negedge aclk) begin : seg_driver
        logic        nxt_valid;
        logic [95:0] nxt_data;
        nxt_valid = s_axis_tvalid;
        nxt_data = s_axis_tdata;
        if (aresetn && segs_taken == segs_sent) begin
            nxt_valid = 1'b0;
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
            end else if (seg_q.size() != 0) begin
                nxt_valid = 1'b1;
                nxt_data = seg_q.pop_front();
                segs_sent <= segs_sent + 1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata <= nxt_data;
    end

    // receiver stall pattern, cycling through four characters
    always @(negedge aclk) begin : tile_sink
        logic rdy;
        rdy = 1'b1;
        if (aresetn) begin
            rx_cycle <= rx_cycle + 1;
            case ((rx_cycle / 256) % 4)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 3) != 0);
                2: rdy = ($urandom_range(0, 1) != 0);
                default: begin
                    if (stall_left != 0) begin
                        rdy = 1'b0;
                        stall_left <= stall_left - 1;
                    end else if ($urandom_range(0, 4) == 0) begin
                        rdy = 1'b0;
                        stall_left <= $urandom_range(0, 11);
                    end
                end
            endcase
        end else begin
            rdy = 1'b0;
        end
        m_axis_tready <= rdy;
    end

    // monitor: predict on each accepted segment, check each tile beat
    always @(posedge aclk) begin : tile_monitor
        tile_t exp_t;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                walk_segment(s_axis_tdata);
                segs_taken <= segs_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (tile_q.size() == 0) begin
                    $display("%0t: unexpected tile beat x=%0d y=%0d last=%b cut=%b", $time,
                             $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                             m_axis_tlast, m_axis_tuser[0]);
                    failed = 1'b1;
                end else begin
                    exp_t = tile_q.pop_front();
                    if (m_axis_tdata[15:0] !== exp_t.x) begin
                        $display("%0t: tile_x expected %0d actual %0d", $time,
                                 $signed(exp_t.x), $signed(m_axis_tdata[15:0]));
                        failed = 1'b1;
                    end
                    if (m_axis_tdata[31:16] !== exp_t.y) begin
                        $display("%0t: tile_y expected %0d actual %0d", $time,
                                 $signed(exp_t.y), $signed(m_axis_tdata[31:16]));
                        failed = 1'b1;
                    end
                    if (m_axis_tlast !== exp_t.last) begin
                        $display("%0t: last expected %b actual %b", $time,
                                 exp_t.last, m_axis_tlast);
                        failed = 1'b1;
                    end
                    if (m_axis_tuser[0] !== exp_t.cut) begin
                        $display("%0t: truncated expected %b actual %b", $time,
                                 exp_t.cut, m_axis_tuser[0]);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        // single tile, also at both corners of the range
        queue_seg(make_seg(0, 0, 0, 0));
        queue_seg(make_seg(10, 20, 250, 200));
        queue_seg(make_seg(8388607, 8388607, 8388352, 8388352));
        queue_seg(make_seg(-8388608, -8388608, -8388353, -8388353));
        // rows and columns both ways, negative ones starting on a boundary
        queue_seg(make_seg(261, 768, 1795, 896));
        queue_seg(make_seg(1280, 300, 256, 400));
        queue_seg(make_seg(700, 100, 650, 2000));
        queue_seg(make_seg(900, 2048, 800, 130));
        // exact diagonal through corners, ties step y
        queue_seg(make_seg(0, 0, 768, 768));
        // both axes on a boundary moving negative
        queue_seg(make_seg(1024, 1024, 256, 128));
        // only x on a boundary moving negative
        queue_seg(make_seg(1024, 1152, 256, 384));
        // negative coordinates, mixed directions
        queue_seg(make_seg(-640, -16, 384, -912));
        queue_seg(make_seg(4660, -1383, -801, 2202));
        queue_seg(make_seg(128, 128, 2688, 384));
        // exactly the maximum run, then one tile over
        queue_seg(make_seg(0, 0, 63 * 256 + 10, 0));
        queue_seg(make_seg(0, 0, 64 * 256, 0));
        queue_seg(make_seg(0, 0, 0, -63 * 256 - 1));
        // full range segments, cut short
        queue_seg(make_seg(-8388608, -8388608, 8388607, 8388607));
        queue_seg(make_seg(8388607, 8388607, -8388608, -8388608));
        queue_seg(make_seg(8388607, -8388608, 8388607, 8388607));
        queue_seg(make_seg(-8388608, 8388607, 8388607, 8388607));
        for (int i = 0; i < RANDOM_SEGS; i++) queue_seg(rand_seg());
        segs_total = seg_q.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (segs_taken != segs_total || tile_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (!failed) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
